// File: rtl/spd_pkg.sv
package spd_pkg;

  localparam int MAX_ROUNDS = 27;
  localparam int RND_W      = 5;
  localparam int WORD_W     = 32;
  localparam int SUM_WIDTH  = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY0      = 3'd0,
    CFG_KEY1      = 3'd1,
    CFG_KEY2      = 3'd2,
    CFG_KEY3      = 3'd3,
    CFG_FIRST     = 3'd4,
    CFG_STOP      = 3'd5,
    CFG_IN_DIFF   = 3'd6,
    CFG_OUT_MASK  = 3'd7
  } cfg_idx_t;

  // state of one word as it walks the chain: both encryptions plus key schedule window
  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] da;
    logic [WORD_W-1:0] db;
    logic [WORD_W-1:0] k;
    logic [WORD_W-1:0] l0;
    logic [WORD_W-1:0] l1;
    logic [WORD_W-1:0] l2;
    logic              restart;
  } stage_t;

  typedef struct packed {
    logic [RND_W-1:0] first;
    logic [RND_W-1:0] stop_eff;
  } rnd_ctl_t;

  function automatic logic [WORD_W-1:0] ror8(input logic [WORD_W-1:0] x);
    return {x[7:0], x[WORD_W-1:8]};
  endfunction

  function automatic logic [WORD_W-1:0] rol3(input logic [WORD_W-1:0] x);
    return {x[WORD_W-4:0], x[WORD_W-1:WORD_W-3]};
  endfunction

endpackage

// File: rtl/spd_if.sv
interface spd_in_if;
  logic                        valid;
  logic                        ready;
  logic [spd_pkg::WORD_W-1:0]  plain_a;
  logic [spd_pkg::WORD_W-1:0]  plain_b;
  logic                        restart;

  modport source (output valid, output plain_a, output plain_b, output restart, input ready);
  modport sink   (input valid, input plain_a, input plain_b, input restart, output ready);
endinterface

interface spd_out_if;
  logic                                valid;
  logic                                ready;
  logic [spd_pkg::WORD_W-1:0]          cipher_a;
  logic [spd_pkg::WORD_W-1:0]          cipher_b;
  logic                                parity_bit;
  logic signed [spd_pkg::SUM_WIDTH-1:0] running_sum;

  modport source (output valid, output cipher_a, output cipher_b, output parity_bit,
                  output running_sum, input ready);
  modport sink   (input valid, input cipher_a, input cipher_b, input parity_bit,
                  input running_sum, output ready);
endinterface

// File: rtl/spd_cell.sv
module spd_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [spd_pkg::RND_W-1:0]   rnd_idx,
  input  spd_pkg::rnd_ctl_t           ctl,
  input  logic                        en,
  input  logic                        v_in,
  input  spd_pkg::stage_t             st_in,
  output logic                        v_r,
  output spd_pkg::stage_t             st_r
);

  logic                          active;
  logic [spd_pkg::WORD_W-1:0]    ra;
  logic [spd_pkg::WORD_W-1:0]    rda;
  logic [spd_pkg::WORD_W-1:0]    mid;
  spd_pkg::stage_t               st_nxt;

  always_comb begin
    active = (rnd_idx >= ctl.first) && (rnd_idx < ctl.stop_eff);
    ra     = (spd_pkg::ror8(st_in.a) + st_in.b) ^ st_in.k;
    rda    = (spd_pkg::ror8(st_in.da) + st_in.db) ^ st_in.k;
    // schedule step, always taken so the key for the next cell is ready
    mid    = (spd_pkg::ror8(st_in.l0) + st_in.k)
             ^ {{(spd_pkg::WORD_W-spd_pkg::RND_W){1'b0}}, rnd_idx};

    st_nxt         = st_in;
    st_nxt.k       = spd_pkg::rol3(st_in.k) ^ mid;
    st_nxt.l0      = st_in.l1;
    st_nxt.l1      = st_in.l2;
    st_nxt.l2      = mid;
    if (active) begin
      st_nxt.a  = ra;
      st_nxt.b  = spd_pkg::rol3(st_in.b) ^ ra;
      st_nxt.da = rda;
      st_nxt.db = spd_pkg::rol3(st_in.db) ^ rda;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

endmodule

// File: rtl/spd_acc.sv
module spd_acc (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 v_in,
  input  spd_pkg::stage_t                      st_in,
  input  logic [spd_pkg::CFG_DATA_W-1:0]       out_mask,
  input  logic                                 out_ready,
  output logic                                 load,
  output logic                                 out_valid_r,
  output logic [spd_pkg::WORD_W-1:0]           cipher_a_r,
  output logic [spd_pkg::WORD_W-1:0]           cipher_b_r,
  output logic                                 parity_r,
  output logic signed [spd_pkg::SUM_WIDTH-1:0] sum_r
);

  logic                                 par;
  logic signed [spd_pkg::SUM_WIDTH-1:0] base;
  logic signed [spd_pkg::SUM_WIDTH-1:0] sum_nxt;

  always_comb begin
    load = !out_valid_r || out_ready;
    par  = ^({st_in.a ^ st_in.da, st_in.b ^ st_in.db} & out_mask);
    base = st_in.restart ? '0 : sum_r;
    sum_nxt = base;
    if (!par) begin
      if (base != spd_pkg::SUM_MAX) sum_nxt = base + {{(spd_pkg::SUM_WIDTH-1){1'b0}}, 1'b1};
    end else begin
      if (base != spd_pkg::SUM_MIN) sum_nxt = base - {{(spd_pkg::SUM_WIDTH-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sum_r       <= '0;
    end else if (load) begin
      out_valid_r <= v_in;
      if (v_in) sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && v_in) begin
      cipher_a_r <= st_in.a;
      cipher_b_r <= st_in.b;
      parity_r   <= par;
    end
  end

endmodule

// File: rtl/speck64_diff_linear_counter.sv
// path: an accepted word passes through 27 round cells and the output stage to its result word
// throughput: one word per cycle while the receiver takes results, set by the round cell chain, one round per cell
// each cell also advances the key schedule, so a new key is in force from the next word
// backpressure holds only the cells that are full; bubbles close up
// reset (rst_n low, synchronous) empties the chain, clears the running sum and
// restores the registers: key words and first round 0, stop round 27, masks 0
module speck64_diff_linear_counter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  spd_in_if.sink                               in_ch,
  spd_out_if.source                            out_ch,
  input  logic                                 cfg_we,
  input  logic [spd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [spd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int NCELL = spd_pkg::MAX_ROUNDS;

  // configuration registers
  logic [spd_pkg::WORD_W-1:0]     key0_r, key1_r, key2_r, key3_r;
  logic [spd_pkg::RND_W-1:0]      first_r, stop_r;
  logic [spd_pkg::CFG_DATA_W-1:0] in_diff_r, out_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r     <= '0;
      key1_r     <= '0;
      key2_r     <= '0;
      key3_r     <= '0;
      first_r    <= '0;
      stop_r     <= spd_pkg::RND_W'(spd_pkg::MAX_ROUNDS);
      in_diff_r  <= '0;
      out_mask_r <= '0;
    end else if (cfg_we) begin
      case (spd_pkg::cfg_idx_t'(cfg_index))
        spd_pkg::CFG_KEY0:     key0_r     <= cfg_data[spd_pkg::WORD_W-1:0];
        spd_pkg::CFG_KEY1:     key1_r     <= cfg_data[spd_pkg::WORD_W-1:0];
        spd_pkg::CFG_KEY2:     key2_r     <= cfg_data[spd_pkg::WORD_W-1:0];
        spd_pkg::CFG_KEY3:     key3_r     <= cfg_data[spd_pkg::WORD_W-1:0];
        spd_pkg::CFG_FIRST:    first_r    <= cfg_data[spd_pkg::RND_W-1:0];
        spd_pkg::CFG_STOP:     stop_r     <= cfg_data[spd_pkg::RND_W-1:0];
        spd_pkg::CFG_IN_DIFF:  in_diff_r  <= cfg_data;
        spd_pkg::CFG_OUT_MASK: out_mask_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stop round clipped to the schedule length; an empty range simply leaves every cell idle
  spd_pkg::rnd_ctl_t ctl;
  always_comb begin
    ctl.first    = first_r;
    ctl.stop_eff = (stop_r > spd_pkg::RND_W'(spd_pkg::MAX_ROUNDS))
                   ? spd_pkg::RND_W'(spd_pkg::MAX_ROUNDS) : stop_r;
  end

  // word entering the chain: plain and difference copies, key schedule seed
  spd_pkg::stage_t entry;
  always_comb begin
    entry.a       = in_ch.plain_a;
    entry.b       = in_ch.plain_b;
    entry.da      = in_ch.plain_a ^ in_diff_r[2*spd_pkg::WORD_W-1:spd_pkg::WORD_W];
    entry.db      = in_ch.plain_b ^ in_diff_r[spd_pkg::WORD_W-1:0];
    entry.k       = key0_r;
    entry.l0      = key1_r;
    entry.l1      = key2_r;
    entry.l2      = key3_r;
    entry.restart = in_ch.restart;
  end

  // chain of round cells; cell i applies round i when it lies in the range
  spd_pkg::stage_t st   [NCELL+1];
  logic [NCELL:0]  v;
  logic [NCELL:0]  en;     // en[i] loads cell i; en[NCELL] is the output stage
  logic            acc_load;

  assign st[0]     = entry;
  assign v[0]      = in_ch.valid;
  assign en[NCELL] = acc_load;

  genvar gi;
  generate
    for (gi = 0; gi < NCELL; gi++) begin : g_cell
      logic            cv_r;
      spd_pkg::stage_t cst_r;

      // a cell may load when empty or when its contents move on
      assign en[gi] = !cv_r || en[gi+1];

      spd_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .rnd_idx (spd_pkg::RND_W'(gi)),
        .ctl     (ctl),
        .en      (en[gi]),
        .v_in    (v[gi]),
        .st_in   (st[gi]),
        .v_r     (cv_r),
        .st_r    (cst_r)
      );

      assign v[gi+1]  = cv_r;
      assign st[gi+1] = cst_r;
    end
  endgenerate

  assign in_ch.ready = en[0];

  // parity, saturating sum and output register
  spd_acc u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .v_in        (v[NCELL]),
    .st_in       (st[NCELL]),
    .out_mask    (out_mask_r),
    .out_ready   (out_ch.ready),
    .load        (acc_load),
    .out_valid_r (out_ch.valid),
    .cipher_a_r  (out_ch.cipher_a),
    .cipher_b_r  (out_ch.cipher_b),
    .parity_r    (out_ch.parity_bit),
    .sum_r       (out_ch.running_sum)
  );

  // accepted word lands in the first cell
  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v[1])
    else $error("accepted word not in first cell");

  // a word leaving the last cell becomes a visible result
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    v[NCELL] && acc_load |=> out_ch.valid)
    else $error("result word lost at output stage");

  // a restart word leaves the sum at plus or minus one
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    v[NCELL] && acc_load && st[NCELL].restart |=>
      (out_ch.running_sum == 48'sd1) || (out_ch.running_sum == -48'sd1))
    else $error("restart did not clear the running sum");

endmodule

// File: tb/spd_bias_checker.sv
module spd_bias_checker
  import spd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  spd_in_if                     in_mon,
  spd_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending_count,
  output int                    compared_count
);

  typedef struct {
    logic [WORD_W-1:0]           cipher_a;
    logic [WORD_W-1:0]           cipher_b;
    logic                        parity_bit;
    logic signed [SUM_WIDTH-1:0] running_sum;
  } bias_word_t;

  // shadow copy of the register file
  logic [WORD_W-1:0]           key_shadow [0:3];
  logic [RND_W-1:0]            first_shadow;
  logic [RND_W-1:0]            stop_shadow;
  logic [63:0]                 diff_shadow;
  logic [63:0]                 mask_shadow;
  logic signed [SUM_WIDTH-1:0] bias_total;

  bias_word_t expected_words [$];
  int         report_count;

  function automatic logic [WORD_W-1:0] rotr8(input logic [WORD_W-1:0] x);
    return {x[7:0], x[WORD_W-1:8]};
  endfunction

  function automatic logic [WORD_W-1:0] rotl3(input logic [WORD_W-1:0] x);
    return {x[WORD_W-4:0], x[WORD_W-1:WORD_W-3]};
  endfunction

  // both encryptions over the configured round range, then masked parity
  function automatic bias_word_t encrypt_pair_parity(input logic [WORD_W-1:0] pa,
                                                     input logic [WORD_W-1:0] pb);
    logic [WORD_W-1:0] rk [0:MAX_ROUNDS];
    logic [WORD_W-1:0] lw [0:MAX_ROUNDS+2];
    logic [WORD_W-1:0] mix, ca, cb, da, db;
    int                lo, hi;
    bias_word_t        res;
    rk[0] = key_shadow[0];
    lw[0] = key_shadow[1];
    lw[1] = key_shadow[2];
    lw[2] = key_shadow[3];
    for (int i = 0; i < MAX_ROUNDS; i++) begin
      mix       = (rotr8(lw[i]) + rk[i]) ^ i;
      rk[i + 1] = mix ^ rotl3(rk[i]);
      lw[i + 3] = mix;
    end
    hi = (stop_shadow > MAX_ROUNDS) ? MAX_ROUNDS : int'(stop_shadow);
    lo = int'(first_shadow);
    if (lo > hi) lo = hi;
    ca = pa;
    cb = pb;
    da = pa ^ diff_shadow[63:32];
    db = pb ^ diff_shadow[31:0];
    for (int r = lo; r < hi; r++) begin
      ca = (rotr8(ca) + cb) ^ rk[r];
      cb = rotl3(cb) ^ ca;
      da = (rotr8(da) + db) ^ rk[r];
      db = rotl3(db) ^ da;
    end
    res.cipher_a    = ca;
    res.cipher_b    = cb;
    res.parity_bit  = ^({ca ^ da, cb ^ db} & mask_shadow);
    res.running_sum = '0;
    return res;
  endfunction

  task automatic flag_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    fail_count++;
    if (report_count < 10) begin
      report_count++;
      $display("%0t: %s mismatch on word %0d: expected %h, got %h",
               $time, field, compared_count, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    bias_word_t got, want;
    if (!rst_n) begin
      expected_words.delete();
      key_shadow[0] = '0;
      key_shadow[1] = '0;
      key_shadow[2] = '0;
      key_shadow[3] = '0;
      first_shadow  = '0;
      stop_shadow   = RND_W'(MAX_ROUNDS);
      diff_shadow   = '0;
      mask_shadow   = '0;
      bias_total    = '0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.cipher_a    = out_mon.cipher_a;
        got.cipher_b    = out_mon.cipher_b;
        got.parity_bit  = out_mon.parity_bit;
        got.running_sum = out_mon.running_sum;
        if (expected_words.size() == 0) begin
          fail_count++;
          if (report_count < 10) begin
            report_count++;
            $display("%0t: result word with nothing expected: %h %h %b %h", $time,
                     got.cipher_a, got.cipher_b, got.parity_bit, got.running_sum);
          end
        end else begin
          want = expected_words.pop_front();
          if (got.cipher_a !== want.cipher_a)
            flag_mismatch("cipher_a", 64'(want.cipher_a), 64'(got.cipher_a));
          if (got.cipher_b !== want.cipher_b)
            flag_mismatch("cipher_b", 64'(want.cipher_b), 64'(got.cipher_b));
          if (got.parity_bit !== want.parity_bit)
            flag_mismatch("parity_bit", 64'(want.parity_bit), 64'(got.parity_bit));
          if (got.running_sum !== want.running_sum)
            flag_mismatch("running_sum", 64'(want.running_sum), 64'(got.running_sum));
          compared_count++;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        want = encrypt_pair_parity(in_mon.plain_a, in_mon.plain_b);
        if (in_mon.restart) bias_total = '0;
        if (!want.parity_bit) begin
          if (bias_total != SUM_MAX) bias_total = bias_total + 1'b1;
        end else begin
          if (bias_total != SUM_MIN) bias_total = bias_total - 1'b1;
        end
        want.running_sum = bias_total;
        expected_words.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_KEY0:     key_shadow[0] = cfg_data[WORD_W-1:0];
          CFG_KEY1:     key_shadow[1] = cfg_data[WORD_W-1:0];
          CFG_KEY2:     key_shadow[2] = cfg_data[WORD_W-1:0];
          CFG_KEY3:     key_shadow[3] = cfg_data[WORD_W-1:0];
          CFG_FIRST:    first_shadow  = cfg_data[RND_W-1:0];
          CFG_STOP:     stop_shadow   = cfg_data[RND_W-1:0];
          CFG_IN_DIFF:  diff_shadow   = cfg_data;
          CFG_OUT_MASK: mask_shadow   = cfg_data;
          default: ;
        endcase
      end
    end
    pending_count = expected_words.size();
  end

endmodule

// File: tb/tb_speck64_diff_linear_counter.sv
module tb_speck64_diff_linear_counter;
  import spd_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;  // several times the slowest correct run
  localparam int LONG_HOLD     = 150;     // receiver stall, well past the chain depth
  localparam int HOLD_AT_WORD  = 300;
  localparam int RANDOM_PHASES = 16;
  localparam int PHASE_WORDS   = 50;
  localparam int TAIL_CYCLES   = 40;      // chain is 28 deep

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending_count;
  int compared_count;
  int words_sent;
  int settings_applied;
  int cycle_count = 0;
  bit calm;             // no idling on either side
  bit long_hold_done;

  spd_in_if  in_ch ();
  spd_out_if out_ch ();

  speck64_diff_linear_counter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  spd_bias_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .compared_count (compared_count)
  );

  // clock, period 10
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog: a hung chain or a lost word ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, pending_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // register write, one per cycle, issued at the falling edge
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // every register is written for each setting; junk above the field width
  // checks that the block keeps only the low bits
  task automatic apply_setting(input logic [31:0] k0, input logic [31:0] k1,
                               input logic [31:0] k2, input logic [31:0] k3,
                               input logic [4:0] first, input logic [4:0] stop,
                               input logic [63:0] diff, input logic [63:0] mask);
    write_reg(CFG_KEY0, {$urandom, k0});
    write_reg(CFG_KEY1, {$urandom, k1});
    write_reg(CFG_KEY2, {$urandom, k2});
    write_reg(CFG_KEY3, {$urandom, k3});
    write_reg(CFG_FIRST, {$urandom, 27'($urandom), first});
    write_reg(CFG_STOP, {$urandom, 27'($urandom), stop});
    write_reg(CFG_IN_DIFF, diff);
    write_reg(CFG_OUT_MASK, mask);
    settings_applied++;
  endtask

  // offer one word, possibly after an idle burst, and wait for it to be taken
  task automatic send_word(input logic [31:0] pa, input logic [31:0] pb,
                           input logic rs);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      gap = $urandom_range(1, 18);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.plain_a = pa;
    in_ch.plain_b = pb;
    in_ch.restart = rs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // sender pauses until every outstanding result word has come back
  task automatic wait_drain();
    in_ch.valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // differences and masks: empty, full, one bit, or dense random
  function automatic logic [63:0] pick_pattern();
    case ($urandom_range(0, 4))
      0:       return 64'd0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // receiver side: random bursts of stall, one long hold so the chain fills
  // up and pushes back on the input
  initial begin : result_sink
    int stretch;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && words_sent >= HOLD_AT_WORD) begin
        long_hold_done = 1'b1;
        out_ch.ready   = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (calm || $urandom_range(0, 2) != 0) begin
        out_ch.ready = 1'b1;
        stretch = $urandom_range(1, 24);
      end else begin
        out_ch.ready = 1'b0;
        stretch = $urandom_range(1, 18);
      end
      repeat (stretch - 1) @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [4:0] first, stop;
    logic [31:0] pa, pb;
    // every input known from time zero
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.plain_a    = '0;
    in_ch.plain_b    = '0;
    in_ch.restart    = 1'b0;
    words_sent       = 0;
    settings_applied = 0;
    calm             = 1'b0;

    // synchronous reset, released at a falling edge
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // reset values of the registers: full range, zero key, no difference
    send_word(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_word(32'h0123_4567, 32'h89ab_cdef, 1'b0);
    wait_drain();

    // all-ones key, difference and mask over the full range
    apply_setting('1, '1, '1, '1, 5'd0, 5'd27, '1, '1);
    send_word(32'h0000_0000, 32'h0000_0000, 1'b1);
    send_word(32'hffff_ffff, 32'hffff_ffff, 1'b0);
    send_word(32'haaaa_aaaa, 32'h5555_5555, 1'b0);
    wait_drain();

    // stop round beyond the schedule is clipped to the schedule length
    apply_setting('0, '0, '0, '0, 5'd0, 5'd31, 64'h0000_0040_0000_0000,
                  64'hffff_ffff_0000_0000);
    send_word($urandom, $urandom, 1'b0);
    send_word($urandom, $urandom, 1'b0);
    send_word($urandom, $urandom, 1'b1);
    wait_drain();

    // empty range, first equal to stop: difference passes straight through
    apply_setting($urandom, $urandom, $urandom, $urandom, 5'd5, 5'd5,
                  64'h8000_0000_0000_0001, 64'h0000_0000_0000_0001);
    send_word($urandom, $urandom, 1'b0);
    send_word(32'hffff_ffff, 32'h0000_0000, 1'b0);
    wait_drain();

    // empty range, first above stop
    apply_setting($urandom, $urandom, $urandom, $urandom, 5'd20, 5'd3,
                  {$urandom, $urandom}, {$urandom, $urandom});
    send_word($urandom, $urandom, 1'b0);
    send_word($urandom, $urandom, 1'b0);
    wait_drain();

    // first round at its field maximum, beyond the clipped stop
    apply_setting($urandom, $urandom, $urandom, $urandom, 5'd31, 5'd31,
                  {$urandom, $urandom}, '1);
    send_word($urandom, $urandom, 1'b0);
    send_word($urandom, $urandom, 1'b1);
    wait_drain();

    // single first round, zero mask so parity stays even
    apply_setting($urandom, $urandom, $urandom, $urandom, 5'd0, 5'd1,
                  {$urandom, $urandom}, '0);
    send_word($urandom, $urandom, 1'b0);
    send_word($urandom, $urandom, 1'b0);
    wait_drain();

    // single last round
    apply_setting($urandom, $urandom, $urandom, $urandom, 5'd26, 5'd27,
                  64'd1, '1);
    send_word($urandom, $urandom, 1'b0);
    send_word($urandom, $urandom, 1'b0);
    wait_drain();

    // stop at zero, and stop just past the schedule
    apply_setting($urandom, $urandom, $urandom, $urandom, 5'd0, 5'd0,
                  {$urandom, $urandom}, {$urandom, $urandom});
    send_word($urandom, $urandom, 1'b0);
    send_word($urandom, $urandom, 1'b1);
    wait_drain();
    apply_setting($urandom, $urandom, $urandom, $urandom, 5'd0, 5'd28,
                  {$urandom, $urandom}, {$urandom, $urandom});
    send_word($urandom, $urandom, 1'b0);
    send_word($urandom, $urandom, 1'b0);
    wait_drain();

    // random settings; the last two phases run without idling
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      calm = (ph >= RANDOM_PHASES - 2);
      case ($urandom_range(0, 7))
        0: begin
          first = 5'($urandom_range(0, 31));
          stop  = 5'($urandom_range(0, 31));
        end
        1: begin
          first = 5'd0;
          stop  = 5'd27;
        end
        2: begin
          first = 5'($urandom_range(0, 27));
          stop  = 5'($urandom_range(28, 31));
        end
        default: begin
          first = 5'($urandom_range(0, 8));
          stop  = 5'($urandom_range(first + 1, 27));
        end
      endcase
      apply_setting($urandom, $urandom, $urandom, $urandom, first, stop,
                    pick_pattern(), pick_pattern());
      for (int n = 0; n < PHASE_WORDS; n++) begin
        pa = $urandom;
        pb = $urandom;
        if ($urandom_range(0, 15) == 0) pa = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 15) == 0) pb = $urandom_range(0, 1) ? '1 : '0;
        send_word(pa, pb, $urandom_range(0, 15) == 0);
      end
      wait_drain();
    end

    // let anything stray come out of the chain
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("%0d words sent under %0d register settings, %0d result words checked",
             words_sent, settings_applied, compared_count);
    $display("covered empty and clipped round ranges, long output hold and drain pauses");
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
